/* hdl/biq_pkg.sv */
// Shared widths, register indexes, reset values and the coefficient set type.
package biq_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int HIST_W   = 24;
    localparam int CNT_W    = 8;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = COEF_W;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_COEF_B0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_B1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_B2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_A1 = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_A2 = 3'd4;
    localparam logic [IDX_W-1:0] REG_WARMUP  = 3'd5;

    // Reset values (Q2.16 coefficients, warm-up length in samples)
    localparam logic signed [COEF_W-1:0] RST_COEF_B0 = 18'sd41873;
    localparam logic signed [COEF_W-1:0] RST_COEF_B1 = 18'sd83746;
    localparam logic signed [COEF_W-1:0] RST_COEF_B2 = 18'sd41873;
    localparam logic signed [COEF_W-1:0] RST_COEF_A1 = 18'sd74907;
    localparam logic signed [COEF_W-1:0] RST_COEF_A2 = 18'sd27054;
    localparam logic [CNT_W-1:0]         RST_WARMUP  = 8'd100;

    // Configuration seen by the filter core
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_b0;
        logic signed [COEF_W-1:0] coef_b1;
        logic signed [COEF_W-1:0] coef_b2;
        logic signed [COEF_W-1:0] coef_a1;
        logic signed [COEF_W-1:0] coef_a2;
        logic [CNT_W-1:0]         warmup_samples;
    } biq_cfg_t;

endpackage

/* hdl/biquad_lowpass_with_warmup.sv */
// Top level: biquad low-pass filter with warm-up, input and result registers.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_stall    sample_in[15:0]
//   out       source     out_valid / out_stall  sample_out[15:0]
//   cfg       sink       cfg_we                 cfg_index[2:0], cfg_data[17:0]
//
// One sample per cycle unless stalled; each passes the input, then the result register.
// The rate is set by the output history loop: five products and one adder tree
// between the input register and the history registers, with no register inside.
// Reset clears the history, the warm-up count and the handshake stages, and
// loads the default coefficients. A stalled output holds its beat; the input
// register still takes one more beat, then in_stall rises.
module biquad_lowpass_with_warmup
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [biq_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [biq_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                cfg_we,
    input  logic [biq_pkg::IDX_W-1:0]           cfg_index,
    input  logic [biq_pkg::CFG_W-1:0]           cfg_data
);

    biq_pkg::biq_cfg_t cfg;

    logic                                x_valid_reg, x_valid_next;
    logic signed [biq_pkg::SAMPLE_W-1:0] x_reg, x_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [biq_pkg::SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic signed [biq_pkg::SAMPLE_W-1:0] y;
    logic                                accept;
    logic                                advance;

    biq_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    biq_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .x     (x_reg),
        .y     (y)
    );

    // Move the held sample into the result register when it is free
    assign advance  = x_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = x_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        x_next       = accept ? sample_in : x_reg;
        x_valid_next = accept ? 1'b1 : (advance ? 1'b0 : x_valid_reg);

        sample_out_next = advance ? y : sample_out_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_valid_reg   <= x_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        sample_out_reg <= sample_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

`ifndef ASSERT_OFF
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (x_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while a stage was free");

    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> x_valid_reg && (x_reg == $past(sample_in)))
        else $error("accepted beat not held in the input register");

    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && (sample_out_reg == $past(y)))
        else $error("processed beat did not reach the result register");
`endif

endmodule

/* hdl/biq_cfg.sv */
// Configuration register file: five coefficients and the warm-up length.
module biq_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [biq_pkg::IDX_W-1:0]    cfg_index,
    input  logic [biq_pkg::CFG_W-1:0]    cfg_data,
    output biq_pkg::biq_cfg_t            cfg
);

    biq_pkg::biq_cfg_t cfg_reg;
    biq_pkg::biq_cfg_t cfg_next;

    // Decode the write; indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                biq_pkg::REG_COEF_B0: cfg_next.coef_b0 = $signed(cfg_data);
                biq_pkg::REG_COEF_B1: cfg_next.coef_b1 = $signed(cfg_data);
                biq_pkg::REG_COEF_B2: cfg_next.coef_b2 = $signed(cfg_data);
                biq_pkg::REG_COEF_A1: cfg_next.coef_a1 = $signed(cfg_data);
                biq_pkg::REG_COEF_A2: cfg_next.coef_a2 = $signed(cfg_data);
                biq_pkg::REG_WARMUP:
                    cfg_next.warmup_samples = cfg_data[biq_pkg::CNT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_b0        <= biq_pkg::RST_COEF_B0;
            cfg_reg.coef_b1        <= biq_pkg::RST_COEF_B1;
            cfg_reg.coef_b2        <= biq_pkg::RST_COEF_B2;
            cfg_reg.coef_a1        <= biq_pkg::RST_COEF_A1;
            cfg_reg.coef_a2        <= biq_pkg::RST_COEF_A2;
            cfg_reg.warmup_samples <= biq_pkg::RST_WARMUP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/biq_core.sv */
// Filter core: history registers, warm-up counter and the biquad arithmetic.
module biq_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  biq_pkg::biq_cfg_t                   cfg,
    input  logic                                fire,
    input  logic signed [biq_pkg::SAMPLE_W-1:0] x,
    output logic signed [biq_pkg::SAMPLE_W-1:0] y
);

    localparam int PROD_X_W = biq_pkg::COEF_W + biq_pkg::SAMPLE_W;
    localparam int FF_W     = PROD_X_W + 2;
    localparam int PROD_Y_W = biq_pkg::COEF_W + biq_pkg::HIST_W;
    localparam int ACC_W    = 48;

    localparam logic signed [ACC_W-1:0] HIST_MAX = 48'sh0000_007F_FFFF;
    localparam logic signed [ACC_W-1:0] HIST_MIN = -48'sh0000_0080_0000;
    localparam logic signed [ACC_W-1:0] OUT_MAX  = 48'sh0000_0000_7FFF;
    localparam logic signed [ACC_W-1:0] OUT_MIN  = -48'sh0000_0000_8000;
    localparam logic signed [ACC_W-1:0] RND_HIST = 48'sh0000_0000_8000;
    localparam logic signed [ACC_W-1:0] RND_OUT  = 48'sh0000_0080_0000;

    logic signed [biq_pkg::SAMPLE_W-1:0] x1_reg, x1_next;
    logic signed [biq_pkg::SAMPLE_W-1:0] x2_reg, x2_next;
    logic signed [biq_pkg::HIST_W-1:0]   y1_reg, y1_next;
    logic signed [biq_pkg::HIST_W-1:0]   y2_reg, y2_next;
    logic [biq_pkg::CNT_W-1:0]           cnt_reg, cnt_next;

    logic signed [biq_pkg::COEF_W-1:0] b0, b1, b2, a1, a2;
    logic signed [PROD_X_W-1:0]        p_b0, p_b1, p_b2;
    logic signed [PROD_Y_W-1:0]        p_a1, p_a2;
    logic signed [FF_W-1:0]            ff;
    logic signed [ACC_W-1:0]           acc;
    logic signed [ACC_W-1:0]           hist_full;
    logic signed [ACC_W-1:0]           out_full;
    logic signed [biq_pkg::HIST_W-1:0] hist_sat;
    logic signed [biq_pkg::SAMPLE_W-1:0] out_sat;
    logic                              warm;
    logic signed [biq_pkg::HIST_W-1:0] y_hist;

    assign b0 = cfg.coef_b0;
    assign b1 = cfg.coef_b1;
    assign b2 = cfg.coef_b2;
    assign a1 = cfg.coef_a1;
    assign a2 = cfg.coef_a2;

    // Five independent products
    assign p_b0 = b0 * x;
    assign p_b1 = b1 * x1_reg;
    assign p_b2 = b2 * x2_reg;
    assign p_a1 = a1 * y1_reg;
    assign p_a2 = a2 * y2_reg;

    // Sum at 2^24 scale
    assign ff  = FF_W'(p_b0) + FF_W'(p_b1) + FF_W'(p_b2);
    assign acc = (ACC_W'(ff) <<< 8) - ACC_W'(p_a1) - ACC_W'(p_a2);

    // Round to nearest (ties up) and saturate
    assign hist_full = (acc + RND_HIST) >>> 16;
    assign out_full  = (acc + RND_OUT) >>> 24;

    always_comb
    begin
        if (hist_full > HIST_MAX)
            hist_sat = HIST_MAX[biq_pkg::HIST_W-1:0];
        else if (hist_full < HIST_MIN)
            hist_sat = HIST_MIN[biq_pkg::HIST_W-1:0];
        else
            hist_sat = hist_full[biq_pkg::HIST_W-1:0];

        if (out_full > OUT_MAX)
            out_sat = OUT_MAX[biq_pkg::SAMPLE_W-1:0];
        else if (out_full < OUT_MIN)
            out_sat = OUT_MIN[biq_pkg::SAMPLE_W-1:0];
        else
            out_sat = out_full[biq_pkg::SAMPLE_W-1:0];
    end

    // Pass the sample through while the history fills
    assign warm   = cnt_reg < cfg.warmup_samples;
    assign y      = warm ? x : out_sat;
    assign y_hist = warm ? $signed({x, 8'h00}) : hist_sat;

    // Advance the history on every processed beat
    always_comb
    begin
        x1_next  = x1_reg;
        x2_next  = x2_reg;
        y1_next  = y1_reg;
        y2_next  = y2_reg;
        cnt_next = cnt_reg;
        if (fire)
        begin
            x1_next = x;
            x2_next = x1_reg;
            y1_next = y_hist;
            y2_next = y1_reg;
            if (warm)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg  <= '0;
            x2_reg  <= '0;
            y1_reg  <= '0;
            y2_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            x1_reg  <= x1_next;
            x2_reg  <= x2_next;
            y1_reg  <= y1_next;
            y2_reg  <= y2_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_in_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (x1_reg == $past(x)) && (x2_reg == $past(x1_reg)))
        else $error("input history did not shift");

    a_out_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> y2_reg == $past(y1_reg))
        else $error("output history did not shift");

    a_warm_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && warm) |=> (cnt_reg != '0) && (y1_reg == $past(y_hist)))
        else $error("warm-up step did not count or record the sample");
`endif

endmodule
